@@ rtl/hfl_pkg.sv @@
package hfl_pkg;

  // Character codes used by the scanner
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] CaseDiff = 8'h20;

  // Width of the offsets carried in a result item
  localparam int unsigned FieldBits = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NAME_LOW  = 2'd0,
    CFG_NAME_HIGH = 2'd1,
    CFG_NAME_LEN  = 2'd2,
    CFG_FIRST     = 2'd3
  } cfg_idx_e;

  // Scan phases
  typedef enum logic [2:0] {
    PH_LINE      = 3'd0,
    PH_SKIP      = 3'd1,
    PH_COLON     = 3'd2,
    PH_COLON_TAB = 3'd3,
    PH_LEAD      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_e;

  typedef struct packed {
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [4:0]  name_len;
    logic        first_only;
  } cfg_t;

  typedef struct packed {
    logic                 emit;
    logic                 found;
    logic [FieldBits-1:0] value_start;
    logic [FieldBits-1:0] value_end;
    logic [FieldBits-1:0] name_end;
    logic                 done;
  } res_t;

  // Fold 'A'..'Z' to lower case, leave everything else alone
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r = c + CaseDiff;
    end
    return r;
  endfunction

endpackage

@@ rtl/hfl_cfg_regs.sv @@
module hfl_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output hfl_pkg::cfg_t        cfg_o
);

  hfl_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (hfl_pkg::cfg_idx_e'(cfg_index_i))
        hfl_pkg::CFG_NAME_LOW:  cfg_q.name_low   <= cfg_data_i;
        hfl_pkg::CFG_NAME_HIGH: cfg_q.name_high  <= cfg_data_i;
        hfl_pkg::CFG_NAME_LEN:  cfg_q.name_len   <= cfg_data_i[4:0];
        hfl_pkg::CFG_FIRST:     cfg_q.first_only <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/hfl_scan.sv @@
module hfl_scan #(
  parameter int unsigned MAX_NAME_LEN = 16,
  parameter int unsigned OFFSET_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  hfl_pkg::cfg_t cfg_i,
  output hfl_pkg::res_t res_o
);

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};
  localparam logic [4:0] MaxLen = 5'(MAX_NAME_LEN);
  localparam int unsigned FW = hfl_pkg::FieldBits;

  hfl_pkg::phase_e        phase_q, phase_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [4:0]             mc_q, mc_d;
  logic [OFFSET_BITS-1:0] name_end_q, name_end_d;
  logic [OFFSET_BITS-1:0] vstart_q, vstart_d;
  logic                   stop_q, stop_d;

  logic [OFFSET_BITS-1:0] off_inc;
  logic [OFFSET_BITS-1:0] v_end;
  logic [4:0]             len;
  logic [127:0]           name_chars;
  logic [7:0]             name_byte;
  logic                   hit;
  logic                   is_eol;

  function automatic logic [FW-1:0] OffMaxField();
    return {FW{1'b1}};
  endfunction

  // Clip an offset to the result field width
  function automatic logic [FW-1:0] clip(input logic [OFFSET_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(OffMaxField())) ? OffMaxField() : w[FW-1:0];
  endfunction

  assign off_inc    = (off_q == OffMax) ? off_q : off_q + 1'b1;
  assign len        = (cfg_i.name_len > MaxLen) ? MaxLen : cfg_i.name_len;
  assign name_chars = {cfg_i.name_high, cfg_i.name_low};
  assign name_byte  = name_chars[{mc_q[3:0], 3'b000} +: 8];
  assign is_eol     = (byte_i == hfl_pkg::ChCr) || (byte_i == hfl_pkg::ChLf);

  // Advance the scan by one byte
  always_comb begin
    phase_d    = phase_q;
    mc_d       = mc_q;
    name_end_d = name_end_q;
    vstart_d   = vstart_q;
    stop_d     = stop_q;
    hit        = 1'b0;
    v_end      = '0;

    if (!stop_q) begin
      case (phase_q)
        hfl_pkg::PH_LINE: begin
          if (mc_q < len && hfl_pkg::fold(byte_i) == hfl_pkg::fold(name_byte)) begin
            mc_d = mc_q + 5'd1;
            if (mc_q + 5'd1 == len) begin
              name_end_d = off_inc;
              phase_d    = hfl_pkg::PH_COLON;
            end
          end else begin
            mc_d    = '0;
            phase_d = (byte_i == hfl_pkg::ChLf) ? hfl_pkg::PH_LINE : hfl_pkg::PH_SKIP;
          end
        end
        hfl_pkg::PH_COLON, hfl_pkg::PH_COLON_TAB: begin
          if (byte_i == hfl_pkg::ChSpace) begin
            phase_d = phase_q;
          end else if (byte_i == hfl_pkg::ChTab) begin
            phase_d = hfl_pkg::PH_COLON_TAB;
          end else if (byte_i == hfl_pkg::ChColon) begin
            if (phase_q == hfl_pkg::PH_COLON_TAB) begin
              stop_d = 1'b1;
            end else begin
              phase_d = hfl_pkg::PH_LEAD;
            end
          end else begin
            phase_d = (byte_i == hfl_pkg::ChLf) ? hfl_pkg::PH_LINE : hfl_pkg::PH_SKIP;
          end
          mc_d = '0;
        end
        hfl_pkg::PH_LEAD: begin
          if (byte_i != hfl_pkg::ChSpace) begin
            vstart_d = off_q;
            if (is_eol) begin
              hit     = 1'b1;
              v_end   = off_q;
              phase_d = hfl_pkg::PH_LINE;
            end else begin
              phase_d = hfl_pkg::PH_VALUE;
            end
          end
        end
        hfl_pkg::PH_VALUE: begin
          if (is_eol) begin
            hit     = 1'b1;
            v_end   = off_q;
            phase_d = hfl_pkg::PH_LINE;
          end
        end
        default: begin
          if (byte_i == hfl_pkg::ChLf) begin
            phase_d = hfl_pkg::PH_LINE;
            mc_d    = '0;
          end
        end
      endcase

      // Close an open value at the end of the block
      if (last_i && !hit && !stop_d) begin
        if (phase_d == hfl_pkg::PH_LEAD) begin
          vstart_d = off_inc;
          v_end    = off_inc;
          hit      = 1'b1;
        end else if (phase_d == hfl_pkg::PH_VALUE) begin
          v_end = off_inc;
          hit   = 1'b1;
        end
      end

      if (hit && cfg_i.first_only) begin
        stop_d = 1'b1;
      end
    end

    off_d = off_inc;
  end

  // Build the result for this byte
  always_comb begin
    res_o.emit        = hit || last_i;
    res_o.found       = hit;
    res_o.value_start = hit ? clip(vstart_d) : '0;
    res_o.value_end   = hit ? clip(v_end) : '0;
    res_o.name_end    = hit ? clip(name_end_d) : '0;
    res_o.done        = last_i;
  end

  // Hold the scan state; drop back to the block start after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hfl_pkg::PH_LINE;
      off_q      <= '0;
      mc_q       <= '0;
      name_end_q <= '0;
      vstart_q   <= '0;
      stop_q     <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= hfl_pkg::PH_LINE;
        off_q      <= '0;
        mc_q       <= '0;
        name_end_q <= '0;
        vstart_q   <= '0;
        stop_q     <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        off_q      <= off_d;
        mc_q       <= mc_d;
        name_end_q <= name_end_d;
        vstart_q   <= vstart_d;
        stop_q     <= stop_d;
      end
    end
  end

  // The block end returns the scan to its start
  a_block_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> off_q == '0 && phase_q == hfl_pkg::PH_LINE && !stop_q)
    else $error("scan state not cleared after block end");

  // The match count never passes the name length cap
  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mc_q <= MaxLen)
    else $error("match count beyond name length cap");

endmodule

@@ rtl/header_field_locator.sv @@
// Header field locator: scans a header block one byte per item and reports
// the value span of each line with the configured name, or of the first only.
//
// Input channel s_axis: one byte in tdata, tlast on the final byte of a block.
// Output channel m_axis: tdata = {name_end, value_end, value_start}, tuser =
// found, tlast = done. A result item comes out for each hit and for the last
// byte of every block; other bytes give no result item.
// Configuration channel cfg: register index and 64-bit data, always ready;
// write only while no block is in flight.
//
// A byte is held in the input register, and its result is captured in the
// output register. Throughput is one byte per cycle while the receiver does
// not stall, set by the compare and phase update in the scanner.
// Reset clears the scan state, the configuration and both valid flags.
// When the receiver stalls, the held result stays on m_axis and bytes that
// make no result still pass; a byte that makes a result waits in the input
// register, and s_axis_tready drops once that register is full.
module header_field_locator #(
  parameter int unsigned MAX_NAME_LEN = 16,
  parameter int unsigned OFFSET_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [15:0] value_start, [31:16] value_end, [47:32] name_end
  output logic        m_axis_tuser,  // [0] found
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  hfl_pkg::cfg_t cfg;
  hfl_pkg::res_t res;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_found_q;
  logic        out_done_q;
  logic        accept_in;
  logic        advance;

  hfl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hfl_scan #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .last_i (last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Move a byte on when it makes no result or the output register is free
  assign advance       = in_valid_q && (!res.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept_in     = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_data_q  <= {res.name_end, res.value_end, res.value_start};
      out_found_q <= res.found;
      out_done_q  <= res.done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_done_q;

  // A result without a hit carries no offsets
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("offsets set on a result without a hit");

  // The value never starts before the name ends or after it closes
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[47:32] <= m_axis_tdata[15:0] && m_axis_tdata[15:0] <= m_axis_tdata[31:16])
    else $error("value span out of order");

  // A waiting byte that makes a result never overwrites a stalled output
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && in_valid_q && res.emit |-> !advance)
    else $error("stalled result overwritten");

endmodule
